### rtl/assert_macros.svh
// Assertion macros for the RTL files that check their own logic.
// No dependencies; clk_i and rst_ni must be visible where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define CRCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every rising edge, reset included.
`define CRCD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### rtl/crcd_pkg.sv
// Shared types, constants and codes of the Catmull-Rom curve densifier.
// No dependencies.
package crcd_pkg;

  localparam int MaxPoints   = 1024;
  localparam int PtrW        = $clog2(MaxPoints);
  localparam int CntW        = PtrW + 1;
  localparam int CoordW      = 32;
  localparam int SegW        = 6;
  localparam int MaxSegments = 63;
  localparam int N2W         = 2 * SegW;
  localparam int N3W         = 3 * SegW;
  localparam int DenW        = N3W + 1;
  localparam int RemW        = DenW + 1;
  localparam int QuoW        = 40;
  localparam int AccW        = 64;
  localparam int CoefW       = CoordW + 6;
  localparam int RowW        = 4 * CoordW;

  // Input commands
  localparam logic [1:0] CmdStart  = 2'd0;
  localparam logic [1:0] CmdAppend = 2'd1;
  localparam logic [1:0] CmdEmit   = 2'd2;

  // Register indexes
  localparam logic [1:0] RegSegments = 2'd0;
  localparam logic [1:0] RegClosed   = 2'd1;
  localparam logic [1:0] RegDims     = 2'd2;

  // Multiply-accumulate steps of one coordinate (Horner form)
  localparam logic [2:0] StepBn = 3'd0;
  localparam logic [2:0] StepAn = 3'd1;
  localparam logic [2:0] StepCn = 3'd2;
  localparam logic [2:0] StepC  = 3'd3;
  localparam logic [2:0] StepB  = 3'd4;
  localparam logic [2:0] StepA  = 3'd5;

  typedef struct packed {
    logic [1:0]               command;
    logic signed [CoordW-1:0] coord_x;
    logic signed [CoordW-1:0] coord_y;
    logic signed [CoordW-1:0] coord_z;
    logic signed [CoordW-1:0] coord_m;
  } in_item_t;

  typedef struct packed {
    logic signed [CoordW-1:0] out_x;
    logic signed [CoordW-1:0] out_y;
    logic signed [CoordW-1:0] out_z;
    logic signed [CoordW-1:0] out_m;
    logic                     last_in_span;
    logic                     last_of_curve;
    logic                     store_overflowed;
  } out_item_t;

  // Effective configuration (already clamped)
  typedef struct packed {
    logic [SegW-1:0] segments;
    logic            closed;
    logic [2:0]      dims;
  } cfg_t;

  typedef struct packed {
    logic            mem_we;
    logic [PtrW-1:0] mem_waddr;
    logic            mem_re;
    logic [PtrW-1:0] mem_raddr;
    logic            latch_segs;
    logic            row_we;
    logic [1:0]      row_sel;
    logic            phantom_lo;
    logic            phantom_hi;
    logic [1:0]      dim;
    logic [2:0]      step;
    logic            mul_en;
    logic            div_start;
    logic            res_we;
    logic [SegW-1:0] k;
    logic            push;
    logic            pass;
    logic            last_in_span;
    logic            last_of_curve;
    logic            overflow;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

### rtl/catmull_rom_curve_densifier_top.sv
// Catmull-Rom curve densifier. An emit first fetches four control rows, then per
// point runs, for each coordinate, 6 steps on the shared multiplier and a 40-bit
// quotient on the bit-serial divider, plus the output register hand-off.
// Short curves pass stored points through, one read and then one output per point.
// Reset (rst_ni, async low) clears control state; the point store is not cleared.
`include "assert_macros.svh"

module catmull_rom_curve_densifier_top import crcd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_item_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_item_t  out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [5:0] cfg_data_i
);

  // Configuration registers, written by a transfer on the config channel
  logic [SegW-1:0] seg_q;
  logic            closed_q;
  logic [2:0]      dims_q;
  cfg_t            cfg;
  dp_cmd_t         dp_cmd;
  dp_status_t      dp_status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q    <= SegW'(4);
      closed_q <= 1'b0;
      dims_q   <= 3'd2;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegSegments: seg_q    <= cfg_data_i[SegW-1:0];
        RegClosed:   closed_q <= cfg_data_i[0];
        RegDims:     dims_q   <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // Clamp: zero segments act as one; dims held to 2..4
  always_comb begin
    cfg.segments = (seg_q == '0) ? SegW'(1) : seg_q;
    if (cfg.segments > SegW'(MaxSegments)) cfg.segments = SegW'(MaxSegments);
    cfg.closed = closed_q;
    if (dims_q < 3'd2)      cfg.dims = 3'd2;
    else if (dims_q > 3'd4) cfg.dims = 3'd4;
    else                    cfg.dims = dims_q;
  end

  // Controller: decodes commands, tracks count/span/done, sequences the math
  crcd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .command_i  (in_data_i.command),
    .cfg_i      (cfg),
    .status_i   (dp_status),
    .cmd_o      (dp_cmd)
  );

  // Datapath: store, Horner multiply-accumulate, divider, output register
  crcd_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .cfg_i       (cfg),
    .wdata_i     (in_data_i),
    .status_o    (dp_status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // The end of the curve always closes a span
  `CRCD_ASSERT(a_curve_end_in_span, out_valid_o && out_data_o.last_of_curve |-> out_data_o.last_in_span, "last_of_curve without last_in_span")
  // Unused dimensions read as zero
  `CRCD_ASSERT(a_z_masked, out_valid_o && cfg.dims < 3'd3 |-> out_data_o.out_z == '0, "out_z not zero in 2D")
  // Never push into a full output register
  `CRCD_ASSERT(a_no_overrun, dp_cmd.push |-> dp_status.out_free, "push while output occupied")
  // Nothing is offered while reset is held
  `CRCD_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !out_valid_o, "output valid during reset")

endmodule

### rtl/crcd_div.sv
// Restoring divider, one quotient bit per cycle, for the rounding division.
// Depends on crcd_pkg.
module crcd_div import crcd_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [AccW-1:0] dividend_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [QuoW-1:0] quo_o
);

  localparam int CntBits = $clog2(QuoW + 1);

  logic [RemW-1:0]    rem_q;
  logic [QuoW-1:0]    quo_q;
  logic [DenW-1:0]    den_q;
  logic [CntBits-1:0] cnt_q;
  logic               busy_q;
  logic               done_q;
  logic [RemW-1:0]    shifted;
  logic [RemW:0]      diff;

  assign shifted = {rem_q[RemW-2:0], quo_q[QuoW-1]};
  assign diff    = {1'b0, shifted} - {2'b00, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CntBits'(QuoW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i[QuoW+RemW-1:QuoW];
      quo_q <= dividend_i[QuoW-1:0];
      den_q <= den_i;
    end else if (busy_q) begin
      if (!diff[RemW]) begin
        rem_q <= diff[RemW-1:0];
        quo_q <= {quo_q[QuoW-2:0], 1'b1};
      end else begin
        rem_q <= shifted;
        quo_q <= {quo_q[QuoW-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

### rtl/crcd_dp.sv
// Datapath: point store, control rows, shared multiply-accumulate, divider
// and output register. Depends on crcd_pkg and crcd_div.
module crcd_dp import crcd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dp_cmd_t    cmd_i,
  input  cfg_t       cfg_i,
  input  in_item_t   wdata_i,
  output dp_status_t status_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_item_t  out_data_o
);

  function automatic logic signed [CoefW-1:0] lane_ext(logic [RowW-1:0] row, logic [1:0] d);
    logic signed [CoordW-1:0] v;
    v = row[d*CoordW +: CoordW];
    return CoefW'(v);
  endfunction

  function automatic logic [CoordW-1:0] sat_coord(logic signed [QuoW:0] v);
    logic signed [QuoW:0] hi;
    logic signed [QuoW:0] lo;
    hi = (QuoW+1)'({1'b0, {(CoordW-1){1'b1}}});
    lo = -hi - 1;
    if (v > hi) return hi[CoordW-1:0];
    if (v < lo) return lo[CoordW-1:0];
    return v[CoordW-1:0];
  endfunction

  logic [RowW-1:0] mem [MaxPoints];
  logic [RowW-1:0] rd_q;
  logic [RowW-1:0] row_q [4];

  logic [SegW-1:0] n_q;
  logic [N2W-1:0]  n2_q;
  logic [N3W-1:0]  n3_q;

  logic signed [CoefW-1:0] p0, p1, p2, p3, c0, c3, coef_a, coef_b, coef_c;
  logic signed [AccW-1:0]  mop_a, mul_res, acc_q, pbn_q, pan_q, pcn_q;
  logic signed [N3W:0]     mop_b;
  logic signed [AccW+N3W:0] prod;

  logic [AccW-1:0]     mag, dividend;
  logic                neg_q, div_done;
  logic [QuoW-1:0]     quo;
  logic signed [QuoW:0] qval;
  logic [CoordW-1:0]   res_q [4];

  logic      out_valid_q;
  out_item_t out_q;
  logic [CoordW-1:0] lane_v [4];

  // Point store
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) begin
      mem[cmd_i.mem_waddr] <= {wdata_i.coord_m, wdata_i.coord_z, wdata_i.coord_y, wdata_i.coord_x};
    end
    if (cmd_i.mem_re) begin
      rd_q <= mem[cmd_i.mem_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.row_we) row_q[cmd_i.row_sel] <= rd_q;
    if (cmd_i.latch_segs) begin
      n_q  <= cfg_i.segments;
      n2_q <= N2W'(cfg_i.segments) * N2W'(cfg_i.segments);
      n3_q <= N3W'(cfg_i.segments) * N3W'(cfg_i.segments) * N3W'(cfg_i.segments);
    end
  end

  // Control values with reflected end points, then cubic coefficients
  assign p0 = lane_ext(row_q[0], cmd_i.dim);
  assign p1 = lane_ext(row_q[1], cmd_i.dim);
  assign p2 = lane_ext(row_q[2], cmd_i.dim);
  assign p3 = lane_ext(row_q[3], cmd_i.dim);
  assign c0 = cmd_i.phantom_lo ? (p1 <<< 1) - p2 : p0;
  assign c3 = cmd_i.phantom_hi ? (p2 <<< 1) - p1 : p3;
  assign coef_a = p2 - c0;
  assign coef_b = (c0 <<< 1) - (p1 <<< 2) - p1 + (p2 <<< 2) - c3;
  assign coef_c = -c0 + (p1 <<< 1) + p1 - (p2 <<< 1) - p2 + c3;

  always_comb begin
    unique case (cmd_i.step)
      StepBn: begin
        mop_a = AccW'(coef_b);
        mop_b = signed'({1'b0, N3W'(n_q)});
      end
      StepAn: begin
        mop_a = AccW'(coef_a);
        mop_b = signed'({1'b0, N3W'(n2_q)});
      end
      StepCn: begin
        mop_a = AccW'(p1);
        mop_b = signed'({1'b0, n3_q});
      end
      StepC: begin
        mop_a = AccW'(coef_c);
        mop_b = signed'({1'b0, N3W'(cmd_i.k)});
      end
      StepB, StepA: begin
        mop_a = acc_q;
        mop_b = signed'({1'b0, N3W'(cmd_i.k)});
      end
      default: begin
        mop_a = '0;
        mop_b = '0;
      end
    endcase
  end

  assign prod    = mop_a * mop_b;
  assign mul_res = prod[AccW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      unique case (cmd_i.step)
        StepBn:  pbn_q <= mul_res;
        StepAn:  pan_q <= mul_res;
        StepCn:  pcn_q <= mul_res;
        StepC:   acc_q <= mul_res + pbn_q;
        StepB:   acc_q <= mul_res + pan_q;
        StepA:   acc_q <= mul_res + (pcn_q <<< 1);
        default: acc_q <= acc_q;
      endcase
    end
  end

  // Round half away from zero: (|num| + n^3) / (2 n^3)
  assign mag      = acc_q[AccW-1] ? AccW'(-acc_q) : AccW'(acc_q);
  assign dividend = mag + AccW'(n3_q);

  crcd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .den_i      ({n3_q, 1'b0}),
    .done_o     (div_done),
    .quo_o      (quo)
  );

  assign qval = neg_q ? -signed'({1'b0, quo}) : signed'({1'b0, quo});

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) neg_q <= acc_q[AccW-1];
    if (cmd_i.res_we) res_q[cmd_i.dim] <= sat_coord(qval);
  end

  // Output register
  always_comb begin
    for (int d = 0; d < 4; d++) begin
      if (3'(d) < cfg_i.dims) begin
        lane_v[d] = cmd_i.pass ? rd_q[d*CoordW +: CoordW] : res_q[d];
      end else begin
        lane_v[d] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_q.out_x            <= lane_v[0];
      out_q.out_y            <= lane_v[1];
      out_q.out_z            <= lane_v[2];
      out_q.out_m            <= lane_v[3];
      out_q.last_in_span     <= cmd_i.last_in_span;
      out_q.last_of_curve    <= cmd_i.last_of_curve;
      out_q.store_overflowed <= cmd_i.overflow;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;
  assign status_o.div_done = div_done;
  assign status_o.out_free = !out_valid_q || out_ready_i;

endmodule

### rtl/crcd_ctrl.sv
// Controller: command decode, store bookkeeping and span/point sequencing.
// Depends on crcd_pkg.
module crcd_ctrl import crcd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] command_i,
  input  cfg_t       cfg_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SFetch = 3'd1;
  localparam logic [2:0] SMul   = 3'd2;
  localparam logic [2:0] SDivGo = 3'd3;
  localparam logic [2:0] SDivWt = 3'd4;
  localparam logic [2:0] SOut   = 3'd5;
  localparam logic [2:0] SPRd   = 3'd6;
  localparam logic [2:0] SPOut  = 3'd7;

  logic [2:0]      state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [PtrW-1:0] span_q, span_d;
  logic            done_q, done_d;
  logic            ovf_q, ovf_d;
  logic [2:0]      f_q, f_d;
  logic [2:0]      step_q, step_d;
  logic [1:0]      dim_q, dim_d;
  logic [SegW-1:0] k_q, k_d;
  logic [PtrW-1:0] pidx_q, pidx_d;

  logic [CntW-1:0] n_pts, nspans, span_ext, raw, cnt_eff;
  logic            last_span, last_k, accept;

  assign accept    = in_valid_i && in_ready_o;
  assign span_ext  = CntW'(span_q);
  assign n_pts     = cfg_i.closed ? ((count_q == '0) ? '0 : count_q - 1'b1) : count_q;
  assign nspans    = cfg_i.closed ? n_pts : n_pts - 1'b1;
  assign last_span = (span_ext + 1'b1 == nspans);
  assign last_k    = (k_q == cfg_i.segments);

  // Row address of control point f: span-1+f, wrapped into the ring
  always_comb begin
    raw = span_ext + CntW'(f_q) - 1'b1;
    if (span_q == '0 && f_q == '0) begin
      raw = n_pts - 1'b1;
    end else if (raw >= n_pts) begin
      raw = raw - n_pts;
    end
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    span_d  = span_q;
    done_d  = done_q;
    ovf_d   = ovf_q;
    f_d     = f_q;
    step_d  = step_q;
    dim_d   = dim_q;
    k_d     = k_q;
    pidx_d  = pidx_q;
    cnt_eff = (command_i == CmdStart) ? '0 : count_q;

    cmd_o               = '0;
    cmd_o.mem_waddr     = cnt_eff[PtrW-1:0];
    cmd_o.mem_raddr     = (state_q == SFetch) ? raw[PtrW-1:0] : pidx_q;
    cmd_o.row_sel       = 2'(f_q - 3'd1);
    cmd_o.phantom_lo    = !cfg_i.closed && (span_q == '0);
    cmd_o.phantom_hi    = !cfg_i.closed && (span_ext + CntW'(2) == n_pts);
    cmd_o.dim           = dim_q;
    cmd_o.step          = step_q;
    cmd_o.k             = k_q;
    cmd_o.overflow      = ovf_q;
    cmd_o.last_in_span  = last_k;
    cmd_o.last_of_curve = last_k && last_span;

    unique case (state_q)
      SIdle: begin
        if (accept) begin
          unique case (command_i)
            CmdStart, CmdAppend: begin
              if (command_i == CmdStart) begin
                span_d = '0;
                done_d = 1'b0;
                ovf_d  = 1'b0;
              end
              if (cnt_eff[PtrW]) begin
                ovf_d = 1'b1;
              end else begin
                cmd_o.mem_we = 1'b1;
                count_d      = cnt_eff + 1'b1;
              end
            end
            CmdEmit: begin
              if (!done_q) begin
                if (n_pts < CntW'(4)) begin
                  done_d = 1'b1;
                  pidx_d = '0;
                  if (count_q != '0) state_d = SPRd;
                end else if (span_ext >= nspans) begin
                  done_d = 1'b1;
                end else begin
                  cmd_o.latch_segs = 1'b1;
                  k_d     = (span_q == '0) ? '0 : SegW'(1);
                  f_d     = '0;
                  state_d = SFetch;
                end
              end
            end
            default: ;
          endcase
        end
      end
      SFetch: begin
        cmd_o.mem_re = (f_q != 3'd4);
        cmd_o.row_we = (f_q != 3'd0);
        f_d = f_q + 1'b1;
        if (f_q == 3'd4) begin
          dim_d   = '0;
          step_d  = StepBn;
          state_d = SMul;
        end
      end
      SMul: begin
        cmd_o.mul_en = 1'b1;
        step_d = step_q + 1'b1;
        if (step_q == StepA) state_d = SDivGo;
      end
      SDivGo: begin
        cmd_o.div_start = 1'b1;
        state_d = SDivWt;
      end
      SDivWt: begin
        if (status_i.div_done) begin
          cmd_o.res_we = 1'b1;
          if ({1'b0, dim_q} == cfg_i.dims - 3'd1) begin
            state_d = SOut;
          end else begin
            dim_d   = dim_q + 1'b1;
            step_d  = StepBn;
            state_d = SMul;
          end
        end
      end
      SOut: begin
        if (status_i.out_free) begin
          cmd_o.push = 1'b1;
          if (last_k) begin
            span_d = span_q + 1'b1;
            if (last_span) done_d = 1'b1;
            state_d = SIdle;
          end else begin
            k_d     = k_q + 1'b1;
            dim_d   = '0;
            step_d  = StepBn;
            state_d = SMul;
          end
        end
      end
      SPRd: begin
        cmd_o.mem_re = 1'b1;
        state_d = SPOut;
      end
      SPOut: begin
        cmd_o.pass          = 1'b1;
        cmd_o.last_in_span  = (CntW'(pidx_q) + 1'b1 == count_q);
        cmd_o.last_of_curve = cmd_o.last_in_span;
        if (status_i.out_free) begin
          cmd_o.push = 1'b1;
          if (cmd_o.last_in_span) begin
            state_d = SIdle;
          end else begin
            pidx_d  = pidx_q + 1'b1;
            state_d = SPRd;
          end
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      count_q <= '0;
      span_q  <= '0;
      done_q  <= 1'b0;
      ovf_q   <= 1'b0;
      f_q     <= '0;
      step_q  <= StepBn;
      dim_q   <= '0;
      k_q     <= '0;
      pidx_q  <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      span_q  <= span_d;
      done_q  <= done_d;
      ovf_q   <= ovf_d;
      f_q     <= f_d;
      step_q  <= step_d;
      dim_q   <= dim_d;
      k_q     <= k_d;
      pidx_q  <= pidx_d;
    end
  end

  assign in_ready_o = (state_q == SIdle);

endmodule
